// ===== rtl/kmh_pkg.sv =====
// Shared types and constants for the k-mer minimizer hasher.
// Holds the channel payload structs, controller/datapath links and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package kmh_pkg;

    localparam int HASH_BITS = 64;
    localparam int HALF_BITS = HASH_BITS / 2;
    localparam int POS_BITS  = 32;
    localparam int KLEN_BITS = 11;
    localparam int WLEN_BITS = 7;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_HASH_BASE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_INVERSE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_POWER    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KMER_LEN     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN   = 3'd4;

    // Multiplier schedule: three partial products per 64-bit product, two products.
    localparam logic [2:0] MUL_ISSUES = 3'd6;
    localparam logic [2:0] MUL_LAST   = 3'd6;

    typedef struct packed {
        logic [1:0] letter;
        logic       start_req;
    } kmh_in_t;

    typedef struct packed {
        logic                 kmer_valid;
        logic [HASH_BITS-1:0] kmer_hash;
        logic [POS_BITS-1:0]  kmer_pos;
        logic                 window_valid;
        logic [HASH_BITS-1:0] min_hash;
        logic [POS_BITS-1:0]  min_pos;
    } kmh_out_t;

    typedef struct packed {
        logic       in_load;
        logic       rd_ring;
        logic       prep;
        logic       mul_go;
        logic [2:0] mul_step;
        logic       fin;
        logic       rd_front;
        logic       retire;
        logic       rd_back;
        logic       pop;
        logic       push;
        logic       out_load;
    } kmh_cmd_t;

    typedef struct packed {
        logic kmer_full;
        logic ret_hit;
        logic pop_hit;
        logic out_busy;
    } kmh_status_t;

endpackage

// ===== rtl/kmer_minimizer_hasher_core.sv =====
// Channel     | Direction | Handshake        | Payload
// in          | input     | in_valid/stall   | kmh_in_t (letter, start_req)
// out         | output    | out_valid/stall  | kmh_out_t (k-mer and window minimizer)
// cfg         | input     | cfg_we           | cfg_idx, cfg_data
//
// A request is loaded, reads the letter ring, forms six partial products in turn on the
// shared 32x32 multiplier and closes the roll. Once the first k-mer is full it retires
// and pops queue entries, each a read and a check of the one-port queue memories, then
// pushes and reads the front. Reset clears all sequence state; the memories are not
// cleared. A new request is taken while the previous result waits in the output register.
//
// Top level of the k-mer minimizer hasher; instantiates kmh_ctrl and kmh_dp and uses kmh_pkg.
`timescale 1ns / 1ps

module kmer_minimizer_hasher_core
    import kmh_pkg::*;
#(
    parameter int K_MAX = 1024,
    parameter int W_MAX = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  kmh_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output kmh_out_t                out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [HASH_BITS-1:0]    cfg_data
);

    kmh_cmd_t    cmd;
    kmh_status_t status;

    kmh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kmh_dp #(
        .K_MAX (K_MAX),
        .W_MAX (W_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/kmh_ctrl.sv =====
// Sequencing controller of the k-mer minimizer hasher.
// Steps each request through hashing and queue update; depends on kmh_pkg.
`timescale 1ns / 1ps

module kmh_ctrl
    import kmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  kmh_status_t status,
    output kmh_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_RETRD = 4'd6;
    localparam logic [3:0] S_RETCK = 4'd7;
    localparam logic [3:0] S_POPRD = 4'd8;
    localparam logic [3:0] S_POPCK = 4'd9;
    localparam logic [3:0] S_PUSH  = 4'd10;
    localparam logic [3:0] S_FRD   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_step = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_ring = 1'b1;
                state_next  = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = status.kmer_full ? S_RETRD : S_OUT;
            end
            S_RETRD:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_RETCK;
            end
            S_RETCK:
            begin
                if (status.ret_hit)
                begin
                    cmd.retire = 1'b1;
                    state_next = S_RETRD;
                end
                else
                begin
                    state_next = S_POPRD;
                end
            end
            S_POPRD:
            begin
                cmd.rd_back = 1'b1;
                state_next  = S_POPCK;
            end
            S_POPCK:
            begin
                if (status.pop_hit)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPRD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_FRD;
            end
            S_FRD:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/kmh_dp.sv =====
// Datapath of the k-mer minimizer hasher: configuration, hashes, letter ring,
// shared 32x32 multiplier, minimizer queue memories and output register. Uses kmh_pkg.
`timescale 1ns / 1ps

module kmh_dp
    import kmh_pkg::*;
#(
    parameter int K_MAX = 1024,
    parameter int W_MAX = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  kmh_in_t                 in_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [HASH_BITS-1:0]    cfg_data,
    input  kmh_cmd_t                cmd,
    output kmh_status_t             status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output kmh_out_t                out_data
);

    localparam int KW  = $clog2(K_MAX + 1);
    localparam int RAW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int WW  = $clog2(W_MAX + 1);
    localparam int DAW = (W_MAX > 1) ? $clog2(W_MAX) : 1;

    // Configuration.
    logic [HASH_BITS-1:0] base_reg, inv_reg, tp_reg;
    logic [KLEN_BITS-1:0] klen_reg;
    logic [WLEN_BITS-1:0] wlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= HASH_BITS'(1);
            inv_reg  <= HASH_BITS'(1);
            tp_reg   <= HASH_BITS'(1);
            klen_reg <= KLEN_BITS'(31);
            wlen_reg <= WLEN_BITS'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_HASH_BASE)    base_reg <= cfg_data;
            if (cfg_idx == REG_BASE_INVERSE) inv_reg  <= cfg_data;
            if (cfg_idx == REG_TOP_POWER)    tp_reg   <= cfg_data;
            if (cfg_idx == REG_KMER_LEN)     klen_reg <= cfg_data[KLEN_BITS-1:0];
            if (cfg_idx == REG_WINDOW_LEN)   wlen_reg <= cfg_data[WLEN_BITS-1:0];
        end
    end

    // Lengths clamped into their legal ranges.
    logic [KW-1:0] eff_k;
    logic [WW-1:0] eff_w;

    always_comb
    begin
        if (klen_reg == '0)
            eff_k = KW'(1);
        else if (32'(klen_reg) > 32'(K_MAX))
            eff_k = KW'(K_MAX);
        else
            eff_k = KW'(klen_reg);
        if (wlen_reg == '0)
            eff_w = WW'(1);
        else if (32'(wlen_reg) > 32'(W_MAX))
            eff_w = WW'(W_MAX);
        else
            eff_w = WW'(wlen_reg);
    end

    // Sequence state.
    logic [HASH_BITS-1:0] fwd_reg, rc_reg;
    logic [RAW-1:0]       ring_wr_reg;
    logic [KW-1:0]        ring_fill_reg;
    logic [POS_BITS-1:0]  seen_reg;
    logic                 full_reg;
    logic [WW-1:0]        kseen_reg;
    logic [DAW-1:0]       head_reg;
    logic [WW-1:0]        count_reg;
    logic [1:0]           letter_reg;

    // Working registers.
    logic [1:0]           leave_reg;
    logic [HASH_BITS-1:0] fa_reg, ra_reg;
    logic [HASH_BITS-1:0] prod_reg;
    logic [2:0]           pidx_reg;
    logic                 pvld_reg;
    logic [HASH_BITS-1:0] accf_reg, accr_reg;
    logic [HASH_BITS-1:0] h_reg;
    logic [POS_BITS-1:0]  kpos_reg;
    logic [HASH_BITS-1:0] qh_rd_reg;
    logic [POS_BITS-1:0]  qp_rd_reg;

    logic [1:0]           ring_mem [K_MAX];
    logic [HASH_BITS-1:0] qh_mem [W_MAX];
    logic [POS_BITS-1:0]  qp_mem [W_MAX];

    // Ring read address: kmer_len slots behind the write index.
    logic [KW:0]    ring_sum;
    logic [RAW-1:0] ring_raddr;
    logic [RAW-1:0] ring_wr_inc;

    always_comb
    begin
        ring_sum = (KW+1)'(ring_wr_reg) + (KW+1)'(K_MAX) - (KW+1)'(eff_k);
        if (ring_sum >= (KW+1)'(K_MAX))
            ring_raddr = RAW'(ring_sum - (KW+1)'(K_MAX));
        else
            ring_raddr = RAW'(ring_sum);
        ring_wr_inc = (32'(ring_wr_reg) == K_MAX - 1) ? '0 : ring_wr_reg + RAW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_ring)
            leave_reg <= ring_mem[ring_raddr];
        if (cmd.prep)
            ring_mem[ring_wr_reg] <= letter_reg;
    end

    // A slot not written since the sequence started is read as a zero letter.
    logic [1:0] leave_eff;

    assign leave_eff = (ring_fill_reg >= eff_k) ? leave_reg : 2'd0;

    // Multiples of top_power by a 2-bit letter.
    function automatic logic [HASH_BITS-1:0] tp_times(input logic [HASH_BITS-1:0] tp,
                                                      input logic [1:0] x);
        logic [HASH_BITS-1:0] r;
        begin
            unique case (x)
                2'd0: r = '0;
                2'd1: r = tp;
                2'd2: r = tp << 1;
                default: r = (tp << 1) + tp;
            endcase
            return r;
        end
    endfunction

    // Shared multiplier operand selection.
    logic [HALF_BITS-1:0] ma, mb;

    always_comb
    begin
        unique case (cmd.mul_step)
            3'd0: begin ma = fa_reg[HALF_BITS-1:0];         mb = base_reg[HALF_BITS-1:0]; end
            3'd1: begin ma = fa_reg[HALF_BITS-1:0];         mb = base_reg[HASH_BITS-1:HALF_BITS]; end
            3'd2: begin ma = fa_reg[HASH_BITS-1:HALF_BITS]; mb = base_reg[HALF_BITS-1:0]; end
            3'd3: begin ma = ra_reg[HALF_BITS-1:0];         mb = inv_reg[HALF_BITS-1:0]; end
            3'd4: begin ma = ra_reg[HALF_BITS-1:0];         mb = inv_reg[HASH_BITS-1:HALF_BITS]; end
            3'd5: begin ma = ra_reg[HASH_BITS-1:HALF_BITS]; mb = inv_reg[HALF_BITS-1:0]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // Closing step of the roll.
    logic [HASH_BITS-1:0] fwd_new, rc_new, h_new;

    always_comb
    begin
        fwd_new = accf_reg + HASH_BITS'(letter_reg);
        rc_new  = accr_reg + tp_times(tp_reg, ~letter_reg);
        h_new   = (fwd_new < rc_new) ? fwd_new : rc_new;
    end

    // Queue addressing.
    logic [DAW-1:0] head_inc;
    logic [WW:0]    back_sum;
    logic [DAW-1:0] back_addr;
    logic           q_full;
    logic [DAW-1:0] head_push;
    logic [WW-1:0]  cnt_push;
    logic [WW:0]    push_sum;
    logic [DAW-1:0] push_addr;
    logic [DAW-1:0] q_raddr;

    always_comb
    begin
        head_inc = (32'(head_reg) == W_MAX - 1) ? '0 : head_reg + DAW'(1);
        back_sum = (WW+1)'(head_reg) + (WW+1)'(count_reg) - (WW+1)'(1);
        if (back_sum >= (WW+1)'(W_MAX))
            back_addr = DAW'(back_sum - (WW+1)'(W_MAX));
        else
            back_addr = DAW'(back_sum);
        q_full    = (32'(count_reg) >= W_MAX);
        head_push = q_full ? head_inc : head_reg;
        cnt_push  = q_full ? WW'(W_MAX - 1) : count_reg;
        push_sum  = (WW+1)'(head_push) + (WW+1)'(cnt_push);
        if (push_sum >= (WW+1)'(W_MAX))
            push_addr = DAW'(push_sum - (WW+1)'(W_MAX));
        else
            push_addr = DAW'(push_sum);
        q_raddr = cmd.rd_back ? back_addr : head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_front || cmd.rd_back)
        begin
            qh_rd_reg <= qh_mem[q_raddr];
            qp_rd_reg <= qp_mem[q_raddr];
        end
        if (cmd.push)
        begin
            qh_mem[push_addr] <= h_reg;
            qp_mem[push_addr] <= kpos_reg;
        end
    end

    // Payload working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
            letter_reg <= in_data.letter;
        if (cmd.prep)
        begin
            fa_reg <= full_reg ? fwd_reg - tp_times(tp_reg, leave_eff) : fwd_reg;
            ra_reg <= full_reg ? rc_reg - HASH_BITS'(leave_eff ^ 2'd3) : rc_reg;
        end
        if (cmd.mul_go && cmd.mul_step < MUL_ISSUES)
        begin
            prod_reg <= HASH_BITS'(ma) * HASH_BITS'(mb);
            pidx_reg <= cmd.mul_step;
        end
        // Low half product: a_lo*b_lo plus the two cross terms shifted up.
        if (pvld_reg)
        begin
            if (pidx_reg == 3'd0)
                accf_reg <= prod_reg;
            else if (pidx_reg < 3'd3)
                accf_reg <= accf_reg + {prod_reg[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
            else if (pidx_reg == 3'd3)
                accr_reg <= prod_reg;
            else
                accr_reg <= accr_reg + {prod_reg[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
        end
        if (cmd.fin)
        begin
            h_reg    <= h_new;
            kpos_reg <= seen_reg - POS_BITS'(eff_k) + POS_BITS'(1);
        end
    end

    // Sequence control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= '0;
            rc_reg        <= '0;
            ring_wr_reg   <= '0;
            ring_fill_reg <= '0;
            seen_reg      <= '0;
            full_reg      <= 1'b0;
            kseen_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            pvld_reg      <= 1'b0;
        end
        else
        begin
            pvld_reg <= cmd.mul_go && (cmd.mul_step < MUL_ISSUES);
            if (cmd.in_load && in_data.start_req)
            begin
                fwd_reg       <= '0;
                rc_reg        <= '0;
                ring_wr_reg   <= '0;
                ring_fill_reg <= '0;
                seen_reg      <= '0;
                full_reg      <= 1'b0;
                kseen_reg     <= '0;
                head_reg      <= '0;
                count_reg     <= '0;
            end
            if (cmd.prep)
            begin
                ring_wr_reg <= ring_wr_inc;
                if (32'(ring_fill_reg) < K_MAX)
                    ring_fill_reg <= ring_fill_reg + KW'(1);
            end
            if (cmd.fin)
            begin
                fwd_reg  <= fwd_new;
                rc_reg   <= rc_new;
                seen_reg <= seen_reg + POS_BITS'(1);
                if (seen_reg + POS_BITS'(1) >= POS_BITS'(eff_k))
                    full_reg <= 1'b1;
            end
            if (cmd.retire)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - WW'(1);
            end
            if (cmd.pop)
                count_reg <= count_reg - WW'(1);
            if (cmd.push)
            begin
                head_reg  <= head_push;
                count_reg <= cnt_push + WW'(1);
                if (32'(kseen_reg) < W_MAX)
                    kseen_reg <= kseen_reg + WW'(1);
            end
        end
    end

    // Output register.
    logic     out_valid_reg;
    kmh_out_t out_data_reg;
    kmh_out_t out_data_next;
    logic     win_ok;

    assign win_ok = (kseen_reg >= eff_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        out_data_next = '0;
        if (full_reg)
        begin
            out_data_next.kmer_valid = 1'b1;
            out_data_next.kmer_hash  = h_reg;
            out_data_next.kmer_pos   = kpos_reg;
            if (win_ok)
            begin
                out_data_next.window_valid = 1'b1;
                out_data_next.min_hash     = qh_rd_reg;
                out_data_next.min_pos      = qp_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.kmer_full = full_reg;
    assign status.ret_hit   = (count_reg != '0)
                              && ((kpos_reg - qp_rd_reg) >= POS_BITS'(eff_w));
    assign status.pop_hit   = (count_reg != '0) && (qh_rd_reg > h_reg);
    assign status.out_busy  = out_valid_reg && out_stall;

endmodule

// ===== bench/kmer_minimizer_hasher_core_test.sv =====
// Self-checking testbench for kmer_minimizer_hasher_core: directed and random letter
// streams are checked against a built-in predictor of the canonical hash and minimizer.
// Depends on kmh_pkg and the kmer_minimizer_hasher_core RTL.
`timescale 1ns / 1ps

module kmer_minimizer_hasher_core_test;
    import kmh_pkg::*;

    localparam int KCAP = 1024;
    localparam int WCAP = 64;
    localparam int EXP_DEPTH = 64;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    kmh_in_t                 in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    kmh_out_t                out_data;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = REG_HASH_BASE;
    logic [HASH_BITS-1:0]    cfg_data = '0;

    kmer_minimizer_hasher_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor configuration and sequence state.
    logic [63:0] p_base = 64'd1, p_inv = 64'd1, p_top = 64'd1;
    logic [10:0] p_klen = 11'd31;
    logic [6:0]  p_wlen = 7'd1;
    logic [63:0] seq_fwd, seq_rc;
    logic [1:0]  letters [KCAP];
    int unsigned ring_wr;
    logic [31:0] seen;
    logic        kfull;
    int unsigned kcount;
    logic [63:0] dq_hash [WCAP];
    logic [31:0] dq_pos [WCAP];
    int unsigned dq_head, dq_cnt;

    // Expected results in order, written by the sender and read by the checker.
    kmh_out_t    expected_results [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_cnt = 0;

    task automatic clear_sequence();
        seq_fwd = '0;
        seq_rc = '0;
        for (int i = 0; i < KCAP; i++) letters[i] = '0;
        ring_wr = 0;
        seen = '0;
        kfull = 1'b0;
        kcount = 0;
        dq_head = 0;
        dq_cnt = 0;
    endtask

    task automatic predict_minimizer(input kmh_in_t req, output kmh_out_t res);
        int unsigned k, w, back;
        logic [31:0] p, kpos;
        logic [1:0]  leave;
        logic [63:0] h;
        if (req.start_req) clear_sequence();
        k = (p_klen == 0) ? 1 : (p_klen > KCAP ? KCAP : p_klen);
        w = (p_wlen == 0) ? 1 : (p_wlen > WCAP ? WCAP : p_wlen);
        p = seen;
        if (!kfull)
        begin
            seq_fwd = seq_fwd * p_base + 64'(req.letter);
            seq_rc = seq_rc * p_inv + 64'(req.letter ^ 2'd3) * p_top;
        end
        else
        begin
            leave = letters[(ring_wr + KCAP - k) % KCAP];
            seq_fwd = (seq_fwd - p_top * 64'(leave)) * p_base + 64'(req.letter);
            seq_rc = (seq_rc - 64'(leave ^ 2'd3)) * p_inv + 64'(req.letter ^ 2'd3) * p_top;
        end
        letters[ring_wr] = req.letter;
        ring_wr = (ring_wr + 1) % KCAP;
        seen = p + 1;
        if (!kfull && seen >= k) kfull = 1'b1;
        res = '0;
        if (kfull)
        begin
            kpos = p - 32'(k - 1);
            h = (seq_fwd < seq_rc) ? seq_fwd : seq_rc;
            while (dq_cnt > 0 && (kpos - dq_pos[dq_head]) >= 32'(w))
            begin
                dq_head = (dq_head + 1) % WCAP;
                dq_cnt--;
            end
            // Larger entries leave from the back; equal ones stay so the earliest wins.
            while (dq_cnt > 0 && dq_hash[(dq_head + dq_cnt - 1) % WCAP] > h) dq_cnt--;
            if (dq_cnt >= WCAP)
            begin
                dq_head = (dq_head + 1) % WCAP;
                dq_cnt = WCAP - 1;
            end
            back = (dq_head + dq_cnt) % WCAP;
            dq_hash[back] = h;
            dq_pos[back] = kpos;
            dq_cnt++;
            if (kcount < WCAP) kcount++;
            res.kmer_valid = 1'b1;
            res.kmer_hash = h;
            res.kmer_pos = kpos;
            if (kcount >= w)
            begin
                res.window_valid = 1'b1;
                res.min_hash = dq_hash[dq_head];
                res.min_pos = dq_pos[dq_head];
            end
        end
    endtask

    task automatic send_letter(input logic [1:0] letter, input logic start);
        kmh_in_t req;
        kmh_out_t res;
        req.letter = letter;
        req.start_req = start;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        predict_minimizer(req, res);
        expected_results[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
    endtask

    task automatic send_stream(input int n, input int start_odds);
        for (int i = 0; i < n; i++)
            send_letter(2'($urandom), (i == 0) || ($urandom_range(start_odds - 1) == 0));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Writes all five registers; the block must be idle.
    task automatic program_regs(input logic [63:0] base, input logic [63:0] inv,
                                input logic [63:0] top, input logic [63:0] klen,
                                input logic [63:0] wlen);
        write_reg(REG_HASH_BASE, base);
        write_reg(REG_BASE_INVERSE, inv);
        write_reg(REG_TOP_POWER, top);
        write_reg(REG_KMER_LEN, klen);
        write_reg(REG_WINDOW_LEN, wlen);
        cfg_we <= 1'b0;
        p_base = base;
        p_inv = inv;
        p_top = top;
        p_klen = klen[10:0];
        p_wlen = wlen[6:0];
    endtask

    // Consistent random parameters: odd base, its inverse and base^(k-1).
    task automatic program_random(input int klen, input int wlen);
        logic [63:0] b, x, t;
        int k;
        b = ($urandom_range(3) == 0) ? 64'd1 : {$urandom, $urandom} | 64'd1;
        x = b;
        repeat (6) x = x * (64'd2 - b * x);
        k = (klen == 0) ? 1 : (klen > KCAP ? KCAP : klen);
        t = 64'd1;
        for (int i = 1; i < k; i++) t = t * b;
        program_regs(b, x, t, klen, wlen);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                kmh_out_t e;
                e = expected_results[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (e.kmer_valid !== out_data.kmer_valid || e.kmer_hash !== out_data.kmer_hash
                    || e.kmer_pos !== out_data.kmer_pos
                    || e.window_valid !== out_data.window_valid
                    || e.min_hash !== out_data.min_hash || e.min_pos !== out_data.min_pos)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                    errors++;
                end
            end
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic test_directed();
        program_regs(64'd1, 64'd1, 64'd1, 64'd3, 64'd2);
        send_letter(2'd0, 1'b1);
        send_letter(2'd3, 1'b0);
        send_letter(2'd3, 1'b0);
        send_letter(2'd0, 1'b0);
        send_letter(2'd1, 1'b0);
        send_letter(2'd2, 1'b0);
        send_letter(2'd1, 1'b0);
        send_letter(2'd2, 1'b0);
        send_letter(2'd3, 1'b0);
        send_letter(2'd2, 1'b1);
        send_letter(2'd1, 1'b0);
        send_letter(2'd0, 1'b0);
        send_letter(2'd3, 1'b0);
        drain();
        // Zero lengths act as one; an all-ones base is its own inverse.
        program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd0);
        send_letter(2'd3, 1'b1);
        send_letter(2'd0, 1'b0);
        send_letter(2'd2, 1'b0);
        send_letter(2'd1, 1'b0);
        send_letter(2'd3, 1'b1);
        drain();
    endtask

    task automatic test_window_ties();
        program_regs(64'd1, 64'd1, 64'd1, 64'd2, 64'd4);
        send_stream(40, 1000);
        drain();
        program_regs(64'd1, 64'd1, 64'd1, 64'd5, 64'd64);
        send_stream(60, 1000);
        drain();
    endtask

    task automatic test_idle_phases();
        int idle_set [4] = '{0, 77, 0, 23};
        int stall_set [4] = '{0, 0, 77, 23};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = idle_set[ph];
            recv_stall = stall_set[ph];
            for (int r = 0; r < 2; r++)
            begin
                program_random($urandom_range(1, 12), $urandom_range(1, 64));
                send_stream(30, 40);
                drain();
            end
        end
        send_idle = 0;
        recv_stall = 0;
    endtask

    task automatic test_long_kmers();
        // An out-of-range window length saturates.
        program_random(150, 127);
        send_stream(230, 100000);
        drain();
    endtask

    task automatic test_backpressure();
        program_random(4, 8);
        send_letter(2'd1, 1'b1);
        hold_cnt = 600;
        send_stream(50, 1000);
        drain();
    endtask

    initial
    begin
        clear_sequence();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_window_ties();
        test_idle_phases();
        test_long_kmers();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("kmer_minimizer_hasher_core test passed");
        else
            $display("kmer_minimizer_hasher_core test failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("kmer_minimizer_hasher_core test failed");
        $finish;
    end

endmodule
